/* rtl/ra85_pkg.sv */
// ----------------------------------------------------------------------------
// ra85_pkg
// Shared types and constants of the run-length / ASCII85 stream encoder.
// ----------------------------------------------------------------------------
package ra85_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_NEXT,
    ST_PUSH,
    ST_MUL,
    ST_DIG,
    ST_LOAD,
    ST_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic adv_slot;
    logic rd;
    logic push;
    logic mul;
    logic dig;
    logic load;
    logic final_start;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_valid;
    logic slot_done;
    logic need_mem;
    logic last;
    logic tuple_full;
    logic word_zero;
    logic dig_last;
    logic fin_grp;
    logic fill_zero;
    logic out_busy;
  } stat_t;

  localparam logic       CFG_RLE_ENABLE  = 1'b0;
  localparam logic       CFG_LINE_LENGTH = 1'b1;
  localparam logic [7:0] LINE_RESET      = 8'd72;
  localparam logic [7:0] LINE_MIN        = 8'd5;
  localparam logic [6:0] CHAR_BASE       = 7'd33;
  localparam logic [6:0] CHAR_Z          = 7'd122;
  localparam logic [8:0] KEY_REP_BASE    = 9'd257;
  localparam logic [31:0] RECIP_85       = 32'hC0C0C0C1; // ceil(2^38/85)
  localparam int          RECIP_SHIFT    = 38;
  localparam logic [6:0] DIV_85          = 7'd85;
  localparam logic [2:0] DIGITS          = 3'd5;

endpackage

/* rtl/ra85_ctrl.sv */
// ----------------------------------------------------------------------------
// ra85_ctrl
// Sequencer: steps one accepted byte through run coding, byte emission,
// base-85 conversion and the output register.
// ----------------------------------------------------------------------------
module ra85_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ra85_pkg::stat_t  stat,
  output ra85_pkg::cmd_t   cmd
);

  ra85_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ra85_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ra85_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ra85_pkg::ST_DECIDE;
      end
      ra85_pkg::ST_DECIDE: state_nxt = ra85_pkg::ST_NEXT;
      ra85_pkg::ST_NEXT: begin
        if (!stat.slot_valid) begin
          state_nxt = stat.last ? ra85_pkg::ST_FINAL : ra85_pkg::ST_IDLE;
        end else if (!stat.slot_done) begin
          state_nxt = ra85_pkg::ST_PUSH;
        end
      end
      ra85_pkg::ST_PUSH: begin
        if (stat.tuple_full) begin
          state_nxt = stat.word_zero ? ra85_pkg::ST_LOAD : ra85_pkg::ST_MUL;
        end else begin
          state_nxt = ra85_pkg::ST_NEXT;
        end
      end
      ra85_pkg::ST_MUL: state_nxt = ra85_pkg::ST_DIG;
      ra85_pkg::ST_DIG: begin
        state_nxt = stat.dig_last ? ra85_pkg::ST_LOAD : ra85_pkg::ST_MUL;
      end
      ra85_pkg::ST_LOAD: begin
        if (!stat.out_busy) begin
          state_nxt = stat.fin_grp ? ra85_pkg::ST_IDLE : ra85_pkg::ST_NEXT;
        end
      end
      ra85_pkg::ST_FINAL: begin
        state_nxt = stat.fill_zero ? ra85_pkg::ST_IDLE : ra85_pkg::ST_MUL;
      end
      default: state_nxt = ra85_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ra85_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ra85_pkg::ST_DECIDE: cmd.decide = 1'b1;
      ra85_pkg::ST_NEXT: begin
        if (stat.slot_valid) begin
          cmd.adv_slot = stat.slot_done;
          cmd.rd       = !stat.slot_done && stat.need_mem;
        end
      end
      ra85_pkg::ST_PUSH: cmd.push = 1'b1;
      ra85_pkg::ST_MUL:  cmd.mul  = 1'b1;
      ra85_pkg::ST_DIG:  cmd.dig  = 1'b1;
      ra85_pkg::ST_LOAD: begin
        cmd.load  = !stat.out_busy;
        cmd.clear = !stat.out_busy && stat.fin_grp;
      end
      ra85_pkg::ST_FINAL: begin
        cmd.clear       = stat.fill_zero;
        cmd.final_start = !stat.fill_zero;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/ra85_dp.sv */
// ----------------------------------------------------------------------------
// ra85_dp
// Datapath: config, run coder state, literal store, emission slots,
// tuple packer, base-85 digit unit and the output register.
// ----------------------------------------------------------------------------
module ra85_dp #(
  parameter int MAX_RUN = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [7:0]       cfg_wdata,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [6:0]       out_ch [5],
  output logic [2:0]       out_cnt,
  output logic [2:0]       out_nl,
  output logic             out_eos,
  input  ra85_pkg::cmd_t   cmd,
  output ra85_pkg::stat_t  stat
);

  localparam int AW = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
  localparam logic [8:0] MAX_RUN_W = 9'(MAX_RUN);

  typedef enum logic [1:0] {PH_IDLE, PH_REPEAT, PH_LITERAL} phase_t;
  typedef enum logic [1:0] {K_PAIR, K_LIT, K_RAW} kind_t;
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] key;
    logic [7:0] val;
    logic [7:0] n;
  } slot_t;

  function automatic slot_t mk_pair(input logic [7:0] key, input logic [7:0] val);
    slot_t s;
    s      = '0;
    s.vld  = 1'b1;
    s.kind = K_PAIR;
    s.key  = key;
    s.val  = val;
    return s;
  endfunction

  function automatic slot_t mk_lit(input logic [7:0] n);
    slot_t s;
    s      = '0;
    s.vld  = 1'b1;
    s.kind = K_LIT;
    s.key  = n - 8'd1;
    s.n    = n;
    return s;
  endfunction

  function automatic logic [7:0] rep_key(input logic [7:0] c);
    return 8'(ra85_pkg::KEY_REP_BASE - {1'b0, c});
  endfunction

  // config and stream
  logic       rle_en_r, mode_r, open_r;
  logic [7:0] line_len_r;
  logic [7:0] b_r;
  logic       last_r;

  // run coder
  phase_t     phase_r, ph_n;
  logic [7:0] cnt_r, cnt_n, rv_r, rv_n, p1_r, p1_n, p2_r, p2_n;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  slot_t      e0, e1;
  logic [7:0] lit_mem [MAX_RUN];
  logic [7:0] rdata_r;

  // emission
  slot_t      slot_r [2];
  logic [7:0] pos_r, len0;
  logic [7:0] cur_byte;
  logic       final_byte;

  // packer / converter
  logic [31:0] tw_r, word_nxt, conv_w_r;
  logic [1:0]  tf_r;
  logic [63:0] prod_r;
  logic [25:0] q;
  logic [6:0]  rem;
  logic [2:0]  dig_cnt_r, grp_n_r;
  logic [6:0]  ch_r [5];
  logic        grp_eos_r, fin_grp_r;
  logic [7:0]  col_r;

  // newline
  logic [7:0] eff_len, diff, col_n;
  logic [2:0] nl_n;

  // ---------------- run coder decision ----------------
  always_comb begin
    ph_n    = phase_r;
    cnt_n   = cnt_r;
    rv_n    = rv_r;
    p1_n    = p1_r;
    p2_n    = p2_r;
    wr_en   = 1'b0;
    wr_addr = '0;
    e0      = '0;
    e1      = '0;
    if (!mode_r) begin
      e0      = '0;
      e0.vld  = 1'b1;
      e0.kind = K_RAW;
      e0.val  = b_r;
    end else begin
      if (phase_r == PH_REPEAT) begin
        if (b_r == rv_r) begin
          cnt_n = cnt_r + 8'd1;
          if ({1'b0, cnt_n} >= MAX_RUN_W) begin
            e0   = mk_pair(rep_key(cnt_n), rv_r);
            ph_n = PH_IDLE;
          end
        end else if (cnt_r >= 8'd2) begin
          e0      = mk_pair(rep_key(cnt_r), rv_r);
          rv_n    = b_r;
          cnt_n   = 8'd1;
          wr_en   = 1'b1;
          wr_addr = '0;
        end else begin
          // single byte then a different one: switch to literal
          wr_en   = 1'b1;
          wr_addr = AW'(1);
          p2_n    = rv_r;
          p1_n    = b_r;
          cnt_n   = 8'd2;
          ph_n    = PH_LITERAL;
          if (9'd2 >= MAX_RUN_W) begin
            e0   = mk_lit(8'd2);
            ph_n = PH_IDLE;
          end
        end
      end else if (phase_r == PH_LITERAL && cnt_r >= 8'd1 && cnt_r <= 8'd127) begin
        if (cnt_r >= 8'd3 && b_r == p1_r && b_r == p2_r) begin
          // last two literals plus this byte open a repeat run
          e0    = mk_lit(cnt_r - 8'd2);
          rv_n  = b_r;
          cnt_n = 8'd3;
          ph_n  = PH_REPEAT;
          if (9'd3 >= MAX_RUN_W) begin
            e1   = mk_pair(rep_key(8'd3), b_r);
            ph_n = PH_IDLE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_r);
          p2_n    = p1_r;
          p1_n    = b_r;
          cnt_n   = cnt_r + 8'd1;
          if ({1'b0, cnt_n} >= MAX_RUN_W) begin
            e0   = mk_lit(cnt_n);
            ph_n = PH_IDLE;
          end
        end
      end else begin
        rv_n    = b_r;
        cnt_n   = 8'd1;
        ph_n    = PH_REPEAT;
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      // end of stream: flush the open run
      if (last_r) begin
        if (ph_n == PH_REPEAT) begin
          if (cnt_n >= 8'd2) begin
            if (e0.vld) e1 = mk_pair(rep_key(cnt_n), rv_n);
            else        e0 = mk_pair(rep_key(cnt_n), rv_n);
          end else begin
            if (e0.vld) e1 = mk_pair(8'd0, rv_n);
            else        e0 = mk_pair(8'd0, rv_n);
          end
        end else if (ph_n == PH_LITERAL) begin
          if (e0.vld) e1 = mk_lit(cnt_n);
          else        e0 = mk_lit(cnt_n);
        end
      end
    end
  end

  // ---------------- emission cursor ----------------
  always_comb begin
    case (slot_r[0].kind)
      K_PAIR:  len0 = 8'd2;
      K_LIT:   len0 = slot_r[0].n + 8'd1;
      default: len0 = 8'd1;
    endcase
    if (slot_r[0].kind == K_RAW)    cur_byte = slot_r[0].val;
    else if (pos_r == 8'd0)         cur_byte = slot_r[0].key;
    else if (slot_r[0].kind == K_LIT) cur_byte = rdata_r;
    else                            cur_byte = slot_r[0].val;
    final_byte = (pos_r == len0 - 8'd1) && !slot_r[1].vld;
    word_nxt   = {tw_r[23:0], cur_byte};
  end

  // ---------------- digit step: q = w / 85, rem = w % 85 ----------------
  assign q   = prod_r[63:ra85_pkg::RECIP_SHIFT];
  assign rem = conv_w_r[6:0] - 7'(q[6:0] * ra85_pkg::DIV_85);

  // ---------------- newline position ----------------
  always_comb begin
    eff_len = (line_len_r < ra85_pkg::LINE_MIN) ? ra85_pkg::LINE_MIN : line_len_r;
    diff    = eff_len - col_r;
    if ({1'b0, col_r} + 9'd1 >= {1'b0, eff_len}) begin
      nl_n  = 3'd1;
      col_n = {5'd0, grp_n_r} - 8'd1;
    end else if (diff <= {5'd0, grp_n_r}) begin
      nl_n  = diff[2:0];
      col_n = {5'd0, grp_n_r} - diff;
    end else begin
      nl_n  = 3'd0;
      col_n = col_r + {5'd0, grp_n_r};
    end
  end

  // ---------------- literal store ----------------
  always_ff @(posedge clk) begin
    if (cmd.decide && wr_en) lit_mem[wr_addr] <= b_r;
    if (cmd.rd) rdata_r <= lit_mem[AW'(pos_r - 8'd1)];
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      b_r    <= in_byte;
      last_r <= in_last;
    end
    if (cmd.mul) prod_r <= conv_w_r * ra85_pkg::RECIP_85;
    if (cmd.push && tf_r == 2'd3) begin
      if (word_nxt == 32'd0) begin
        ch_r[0] <= ra85_pkg::CHAR_Z;
        for (int k = 1; k < 5; k++) ch_r[k] <= 7'd0;
        grp_n_r <= 3'd1;
      end else begin
        conv_w_r <= word_nxt;
        grp_n_r  <= ra85_pkg::DIGITS;
      end
    end
    if (cmd.final_start) begin
      conv_w_r <= tw_r << (8 * (4 - {3'd0, tf_r}));
      grp_n_r  <= {1'b0, tf_r} + 3'd1;
    end
    if (cmd.dig) begin
      ch_r[0] <= rem + ra85_pkg::CHAR_BASE;
      for (int k = 0; k < 4; k++) ch_r[k+1] <= ch_r[k];
      conv_w_r <= {6'd0, q};
    end
    if (cmd.load) begin
      for (int k = 0; k < 5; k++) out_ch[k] <= (3'(k) < grp_n_r) ? ch_r[k] : 7'd0;
      out_cnt <= grp_n_r;
      out_nl  <= nl_n;
      out_eos <= grp_eos_r;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_en_r   <= 1'b1;
      line_len_r <= ra85_pkg::LINE_RESET;
      mode_r     <= 1'b1;
      open_r     <= 1'b0;
      phase_r    <= PH_IDLE;
      cnt_r      <= 8'd0;
      rv_r       <= 8'd0;
      p1_r       <= 8'd0;
      p2_r       <= 8'd0;
      slot_r[0]  <= '0;
      slot_r[1]  <= '0;
      pos_r      <= 8'd0;
      tw_r       <= 32'd0;
      tf_r       <= 2'd0;
      dig_cnt_r  <= 3'd0;
      grp_eos_r  <= 1'b0;
      fin_grp_r  <= 1'b0;
      col_r      <= 8'd0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == ra85_pkg::CFG_RLE_ENABLE) rle_en_r <= cfg_wdata[0];
        else line_len_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        open_r <= 1'b1;
        if (!open_r) mode_r <= rle_en_r;
      end
      if (cmd.decide) begin
        phase_r   <= ph_n;
        cnt_r     <= cnt_n;
        rv_r      <= rv_n;
        p1_r      <= p1_n;
        p2_r      <= p2_n;
        slot_r[0] <= e0;
        slot_r[1] <= e1;
        pos_r     <= 8'd0;
      end
      if (cmd.adv_slot) begin
        slot_r[0] <= slot_r[1];
        slot_r[1] <= '0;
        pos_r     <= 8'd0;
      end
      if (cmd.push) begin
        pos_r     <= pos_r + 8'd1;
        grp_eos_r <= last_r && final_byte;
        fin_grp_r <= 1'b0;
        dig_cnt_r <= ra85_pkg::DIGITS;
        if (tf_r == 2'd3) begin
          tw_r <= 32'd0;
          tf_r <= 2'd0;
        end else begin
          tw_r <= word_nxt;
          tf_r <= tf_r + 2'd1;
        end
      end
      if (cmd.final_start) begin
        dig_cnt_r <= ra85_pkg::DIGITS;
        grp_eos_r <= 1'b1;
        fin_grp_r <= 1'b1;
      end
      if (cmd.dig) dig_cnt_r <= dig_cnt_r - 3'd1;
      if (cmd.load) begin
        out_tvalid <= 1'b1;
        col_r      <= col_n;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      if (cmd.clear) begin
        open_r    <= 1'b0;
        phase_r   <= PH_IDLE;
        cnt_r     <= 8'd0;
        rv_r      <= 8'd0;
        tw_r      <= 32'd0;
        tf_r      <= 2'd0;
        col_r     <= 8'd0;
        fin_grp_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.slot_valid = slot_r[0].vld;
    stat.slot_done  = pos_r == len0;
    stat.need_mem   = slot_r[0].kind == K_LIT && pos_r != 8'd0;
    stat.last       = last_r;
    stat.tuple_full = tf_r == 2'd3;
    stat.word_zero  = word_nxt == 32'd0;
    stat.dig_last   = dig_cnt_r == 3'd1;
    stat.fin_grp    = fin_grp_r;
    stat.fill_zero  = tf_r == 2'd0;
    stat.out_busy   = out_tvalid && !out_tready;
  end

endmodule

/* rtl/rle_ascii85_stream_encoder_unit.sv */
// ----------------------------------------------------------------------------
// rle_ascii85_stream_encoder_unit
// Byte stream in, ASCII85 groups out, with optional run-length coding.
// ----------------------------------------------------------------------------
// Sequence: a word is taken and is decided in the next cycle; each coded
//   byte then passes a cursor step (with any literal-store read) and a push,
//   and each run record a further cursor step to advance. A full non-zero tuple
//   then runs the base-85 unit (a multiply and a digit step for each of the 5
//   digits) and the output load; an all-zero tuple goes straight to the load.
// Input: a new word is taken only once all records of the last one are emitted
//   and any group it completes is loaded; a last word adds a final step and,
//   for a partial tuple, its conversion and load. A held output group stalls the load.
// Reset: rst_n synchronous, active low; clears run, tuple, column and output
//   state, rle_enable to 1 and line_length to 72. Literal store is not cleared.
module rle_ascii85_stream_encoder_unit #(
  parameter int MAX_RUN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [6:0] first_char, [13:7] second_char,
                                  // [20:14] third_char, [27:21] fourth_char,
                                  // [34:28] fifth_char, [37:35] char_count,
                                  // [40:38] newline_after, [47:41] zero
  output logic        out_tlast,  // end_of_stream
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,   // 0 rle_enable, 1 line_length
  input  logic [7:0]  cfg_wdata
);

  ra85_pkg::cmd_t  cmd;
  ra85_pkg::stat_t stat;
  logic [6:0]      ch [5];
  logic [2:0]      cnt, nl;

  // sequencer: owns the input handshake and every step of the datapath
  ra85_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: run coder, literal store, packer, digit unit, output register
  ra85_dp #(.MAX_RUN(MAX_RUN)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_ch     (ch),
    .out_cnt    (cnt),
    .out_nl     (nl),
    .out_eos    (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign out_tdata = {7'd0, nl, cnt, ch[4], ch[3], ch[2], ch[1], ch[0]};

endmodule

/* rtl/ra85_checker.sv */
// ----------------------------------------------------------------------------
// ra85_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ra85_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a waiting group is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped before taken");

  // one byte at a time: the encoder is busy right after a take
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // group size and newline place agree
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:35] >= 3'd1 && out_tdata[37:35] <= 3'd5 &&
                   out_tdata[40:38] <= out_tdata[37:35])
    else $error("bad char_count or newline_after");

  // the fifth character is zero on a short group
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[37:35] != 3'd5 |-> out_tdata[34:28] == 7'd0)
    else $error("fifth_char set on short group");

endmodule

bind rle_ascii85_stream_encoder_unit ra85_checker u_ra85_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/rle_ascii85_stream_encoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// rle_ascii85_stream_encoder_unit_tb
// Drives byte streams through the run-coding / ASCII85 encoder and compares
// every output group against an in-bench encoder model, with random gaps,
// receiver stalls, one long output hold-off and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_ascii85_stream_encoder_unit_tb;

  localparam int RUN_MAX   = 128;
  localparam int PH_IDLE   = 0;
  localparam int PH_REPEAT = 1;
  localparam int PH_LIT    = 2;
  localparam int WDOG_MAX  = 60000;

  typedef struct packed {
    logic        eos;
    logic [2:0]  nl_after;
    logic [2:0]  count;
    logic [6:0]  c4, c3, c2, c1, c0;
  } group_t;

  // --------------------------------------------------------------------------
  // Scoreboard: encoder model plus queue of pending groups
  // --------------------------------------------------------------------------
  class a85_scoreboard;
    group_t      pending[$];
    int          errors;
    logic [7:0]  lit_buf[RUN_MAX];
    int          run_len;
    logic [7:0]  run_byte;
    int          phase;
    logic [31:0] tuple;
    int          fill;
    int          column;
    logic        rle_reg;
    logic [7:0]  line_reg;
    logic        open_flag;
    logic        rle_mode;
    int          step_first;

    function new();
      errors = 0;
      rle_reg = 1'b1;
      line_reg = ra85_pkg::LINE_RESET;
      rle_mode = 1'b1;
      clear_stream();
    endfunction

    function void clear_stream();
      run_len = 0; run_byte = 0; phase = PH_IDLE;
      tuple = 0; fill = 0; column = 0; open_flag = 0;
    endfunction

    function void write_reg(logic addr, logic [7:0] val);
      if (addr == ra85_pkg::CFG_RLE_ENABLE) rle_reg = val[0];
      else line_reg = val;
    endfunction

    function void push_group(logic [6:0] ch[5], int n);
      int len, nl, k;
      group_t g;
      len = (line_reg < 5) ? 5 : line_reg;
      nl = 0;
      for (k = 1; k <= n; k++) begin
        column++;
        if (column >= len) begin
          if (nl == 0) nl = k;
          column = 0;
        end
      end
      g.c0 = ch[0];
      g.c1 = (n > 1) ? ch[1] : 7'd0;
      g.c2 = (n > 2) ? ch[2] : 7'd0;
      g.c3 = (n > 3) ? ch[3] : 7'd0;
      g.c4 = (n > 4) ? ch[4] : 7'd0;
      g.count = n[2:0];
      g.nl_after = nl[2:0];
      g.eos = 1'b0;
      pending.push_back(g);
    endfunction

    function void base85(logic [31:0] w, output logic [6:0] ch[5]);
      int k;
      for (k = 4; k >= 0; k--) begin
        ch[k] = 7'(w % 85 + 33);
        w = w / 85;
      end
    endfunction

    function void pack_byte(logic [7:0] b);
      logic [6:0] ch[5];
      tuple = {tuple[23:0], b};
      fill++;
      if (fill < 4) return;
      if (tuple == 0) begin
        ch[0] = ra85_pkg::CHAR_Z; ch[1] = 0; ch[2] = 0; ch[3] = 0; ch[4] = 0;
        push_group(ch, 1);
      end else begin
        base85(tuple, ch);
        push_group(ch, 5);
      end
      tuple = 0; fill = 0;
    endfunction

    function void flush_tuple();
      logic [6:0] ch[5];
      if (fill == 0) return;
      base85(tuple << (8 * (4 - fill)), ch);
      push_group(ch, fill + 1);
      tuple = 0; fill = 0;
    endfunction

    function void put_repeat();
      pack_byte(8'(257 - run_len));
      pack_byte(run_byte);
    endfunction

    function void put_literal(int n);
      int k;
      if (n == 0) return;
      pack_byte(8'(n - 1));
      for (k = 0; k < n; k++) pack_byte(lit_buf[k]);
    endfunction

    function void run_code(logic [7:0] b);
      int c;
      c = run_len & 255;
      if (phase == PH_REPEAT) begin
        if (b == run_byte) begin
          run_len = c + 1;
          if (run_len >= RUN_MAX) begin
            put_repeat(); phase = PH_IDLE;
          end
        end else if (c >= 2) begin
          put_repeat(); run_byte = b; run_len = 1;
        end else begin
          lit_buf[0] = run_byte; lit_buf[1] = b; run_len = 2; phase = PH_LIT;
        end
      end else if (phase == PH_LIT && c >= 1 && c <= 127) begin
        // two equal tail bytes plus a third open a repeat run
        if (c >= 3 && b == lit_buf[c-1] && b == lit_buf[c-2]) begin
          put_literal(c - 2);
          run_byte = b; run_len = 3; phase = PH_REPEAT;
        end else begin
          lit_buf[c] = b; run_len = c + 1;
          if (run_len >= RUN_MAX) begin
            put_literal(run_len); phase = PH_IDLE;
          end
        end
      end else begin
        run_byte = b; run_len = 1; phase = PH_REPEAT;
      end
    endfunction

    function void run_flush();
      if (phase == PH_REPEAT) begin
        if (run_len >= 2) put_repeat();
        else begin
          lit_buf[0] = run_byte; put_literal(1);
        end
      end else if (phase == PH_LIT) put_literal(run_len & 255);
      phase = PH_IDLE; run_len = 0;
    endfunction

    // note an accepted input word
    function void note_byte(logic [7:0] b, logic last);
      step_first = pending.size();
      if (!open_flag) begin
        rle_mode = rle_reg;
        open_flag = 1'b1;
      end
      if (rle_mode) begin
        run_code(b);
        if (last) run_flush();
      end else pack_byte(b);
      if (last) begin
        flush_tuple();
        if (pending.size() > step_first) pending[$].eos = 1'b1;
        clear_stream();
      end
    endfunction

    // check one accepted output word
    function void check_group(logic [47:0] data, logic last);
      group_t got, want;
      got = {last, data[40:0]};
      if (pending.size() == 0) begin
        $display("%0t: unexpected group %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[47:41] != 0 || got != want) begin
        $display("%0t: mismatch exp %h got %h (pad %h)", $time, want, got, data[47:41]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;

  a85_scoreboard sb;
  int  idle_cycles;
  bit  hold_out;
  bit  hold_done;
  bit  timed_out;

  rle_ascii85_stream_encoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // sample both channels at the edge; model update in the same place
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_group(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    int gap;
    int k;
    out_tready = 1'b0;
    hold_done = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out && !hold_done) begin
        out_tready <= 1'b0;
        for (k = 0; k < 3000; k++) @(posedge clk);
        hold_done = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // run flushes may still be in flight with no group to show for them
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(input logic addr, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(addr, val);
    @(posedge clk);
  endtask

  // one random stream: mostly runs and literals of random content
  task automatic send_stream(input int len, input bit burst);
    int k, rep;
    logic [7:0] b;
    k = 0;
    while (k < len) begin
      case ($urandom_range(0, 3))
        0: rep = $urandom_range(1, 3);
        1: rep = $urandom_range(2, 12);
        2: rep = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 140) : 1;
        default: rep = 1;
      endcase
      b = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
      while (rep > 0 && k < len) begin
        send_byte(b, k == len - 1, burst);
        rep--; k++;
      end
    end
  endtask

  initial begin
    int k, n;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 8'd0; in_tlast = 1'b0;
    cfg_we = 1'b0; cfg_addr = ra85_pkg::CFG_RLE_ENABLE; cfg_wdata = 8'd0;
    hold_out = 0; timed_out = 0; idle_cycles = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: single byte 255, run of zeros, five-byte literal, split run
    send_byte(8'hFF, 1'b1, 0);
    for (k = 0; k < 4; k++) send_byte(8'h00, k == 3, 0);
    for (k = 0; k < 5; k++) send_byte(8'(k * 51), k == 4, 0);
    for (k = 0; k < 4; k++) send_byte(k < 2 ? 8'h10 : 8'h20, k == 3, 0);
    drain();
    write_cfg(ra85_pkg::CFG_RLE_ENABLE, 8'd0);
    write_cfg(ra85_pkg::CFG_LINE_LENGTH, 8'd1);
    for (k = 0; k < 4; k++) send_byte(8'h00, 1'b0, 0);
    for (k = 0; k < 3; k++) send_byte(8'hFF, k == 2, 0);
    drain();

    // raw mode, minimum line, bursty input
    send_stream(30, 1);
    drain();
    write_cfg(ra85_pkg::CFG_RLE_ENABLE, 8'd1);
    write_cfg(ra85_pkg::CFG_LINE_LENGTH, 8'd255);
    // full-length literal and repeat runs; long output hold-off here
    hold_out = 1;
    for (k = 0; k < 130; k++) send_byte(8'(k * 7 + 1), 1'b0, 1);
    for (k = 0; k < 130; k++) send_byte(8'h5A, k == 129, 1);
    drain();
    write_cfg(ra85_pkg::CFG_LINE_LENGTH, 8'd7);
    n = 0;
    while (n < 40) begin
      k = $urandom_range(1, 30);
      send_stream(k, $urandom_range(0, 3) == 0);
      n += k;
    end
    drain();
    write_cfg(ra85_pkg::CFG_LINE_LENGTH, 8'd3);
    write_cfg(ra85_pkg::CFG_RLE_ENABLE, 8'd0);
    send_stream(20, 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("rle_ascii85_stream_encoder_unit_tb OK");
    else
      $display("rle_ascii85_stream_encoder_unit_tb NOT OK");
    $finish;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= WDOG_MAX && !timed_out) begin
      timed_out = 1;
      $display("rle_ascii85_stream_encoder_unit_tb NOT OK");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/ra85_pkg.sv
rtl/ra85_ctrl.sv
rtl/ra85_dp.sv
rtl/rle_ascii85_stream_encoder_unit.sv
rtl/ra85_checker.sv
test/rle_ascii85_stream_encoder_unit_tb.sv
